>>> rtl/tmcr_pkg.sv
`default_nettype none

package tmcr_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned DIM_W      = 8;
  localparam int unsigned SIZE_W     = 20;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned TILE_SIZE_PX_DEF  = 64;
  localparam int unsigned MAX_MAP_COLS_DEF  = 128;
  localparam int unsigned MAX_MAP_ROWS_DEF  = 128;
  localparam int unsigned FRACTION_BITS_DEF = 8;

  localparam logic [DIM_W-1:0]  MAP_COLS_RST     = 8'd128;
  localparam logic [DIM_W-1:0]  MAP_ROWS_RST     = 8'd128;
  localparam logic [SIZE_W-1:0] AGENT_SIZE_RST   = 20'd15360;
  localparam logic [SIZE_W-1:0] AGENT_RADIUS_RST = 20'd7680;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COLS     = 2'd0,
    REG_MAP_ROWS     = 2'd1,
    REG_AGENT_SIZE   = 2'd2,
    REG_AGENT_RADIUS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_RESOLVE = 1'b1
  } action_e;

  typedef enum logic {
    SRC_LOAD    = 1'b0,
    SRC_RESOLVE = 1'b1
  } out_src_e;

  typedef struct packed {
    logic       capture;
    logic       cell_wr;
    logic       corn_en;
    logic [1:0] corner;
    logic       div_en;
    logic       rd_en;
    logic       cent_en;
    logic       diff_en;
    logic       depth_en;
    logic       push_en;
    logic       out_load;
    out_src_e   out_sel;
  } tmcr_cmd_t;

  typedef struct packed {
    logic hit;
  } tmcr_sts_t;

endpackage

`default_nettype wire

>>> rtl/tile_map_collision_resolver_top.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o  action, pos_x, pos_y, cell_col, cell_row, cell_solid
// out       source     out_valid_o/out_stall_i new_x, new_y, collided
// cfg       sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
// A load writes the tile bit at the transfer, and the echo lands in the output register
// at the same edge.
// A resolve steps through corner add, reciprocal multiply, tile memory read and center
// for each corner, plus difference, depth and push for each solid corner, then unloads.
// One resolve is in flight at a time; the output register holds a result under stall.
// Reset clears control state and loads the register defaults; the tile map is not cleared.

module tile_map_collision_resolver_top
  import tmcr_pkg::*;
#(
  parameter int unsigned TILE_SIZE_PX  = TILE_SIZE_PX_DEF,
  parameter int unsigned MAX_MAP_COLS  = MAX_MAP_COLS_DEF,
  parameter int unsigned MAX_MAP_ROWS  = MAX_MAP_ROWS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    action_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic [CELL_W-1:0]       cell_col_i,
  input  wire logic [CELL_W-1:0]       cell_row_i,
  input  wire logic                    cell_solid_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [POS_W-1:0]      new_x_o,
  output logic signed [POS_W-1:0]      new_y_o,
  output logic                         collided_o
);

  tmcr_cmd_t cmd;
  tmcr_sts_t sts;

  tmcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tmcr_dp #(
    .TILE_SIZE_PX  (TILE_SIZE_PX),
    .MAX_MAP_COLS  (MAX_MAP_COLS),
    .MAX_MAP_ROWS  (MAX_MAP_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .cell_col_i   (cell_col_i),
    .cell_row_i   (cell_row_i),
    .cell_solid_i (cell_solid_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .new_x_o      (new_x_o),
    .new_y_o      (new_y_o),
    .collided_o   (collided_o)
  );

endmodule

`default_nettype wire

>>> rtl/tmcr_ctrl.sv
`default_nettype none

module tmcr_ctrl
  import tmcr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire logic      action_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire tmcr_sts_t sts_i,
  output tmcr_cmd_t      cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CORN  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_READ  = 9'b000001000,
    S_CENT  = 9'b000010000,
    S_DIFF  = 9'b000100000,
    S_DEPTH = 9'b001000000,
    S_PUSH  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] corner_q, corner_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       in_xfer;
  logic       is_load;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_load     = (action_e'(action_i) == ACT_LOAD);
  assign in_stall_o  = (state_q != S_IDLE) || (is_load && !out_free);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    cmd_o    = '0;
    cmd_o.corner  = corner_q;
    cmd_o.out_sel = SRC_LOAD;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (is_load) begin
            cmd_o.cell_wr  = 1'b1;
            cmd_o.out_load = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            corner_d      = 2'd0;
            state_d       = S_CORN;
          end
        end
      end
      S_CORN: begin
        cmd_o.corn_en = 1'b1;
        state_d       = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CENT;
      end
      S_CENT: begin
        cmd_o.cent_en = 1'b1;
        if (sts_i.hit) begin
          state_d = S_DIFF;
        end else if (corner_q == 2'd3) begin
          state_d = S_DONE;
        end else begin
          corner_d = corner_q + 2'd1;
          state_d  = S_CORN;
        end
      end
      S_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_d       = S_DEPTH;
      end
      S_DEPTH: begin
        cmd_o.depth_en = 1'b1;
        state_d        = S_PUSH;
      end
      S_PUSH: begin
        cmd_o.push_en = 1'b1;
        if (corner_q == 2'd3) begin
          state_d = S_DONE;
        end else begin
          corner_d = corner_q + 2'd1;
          state_d  = S_CORN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SRC_RESOLVE;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      corner_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      corner_q    <= corner_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tmcr_dp.sv
`default_nettype none

module tmcr_dp
  import tmcr_pkg::*;
#(
  parameter int unsigned TILE_SIZE_PX  = TILE_SIZE_PX_DEF,
  parameter int unsigned MAX_MAP_COLS  = MAX_MAP_COLS_DEF,
  parameter int unsigned MAX_MAP_ROWS  = MAX_MAP_ROWS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic [CELL_W-1:0]       cell_col_i,
  input  wire logic [CELL_W-1:0]       cell_row_i,
  input  wire logic                    cell_solid_i,
  input  wire tmcr_cmd_t               cmd_i,
  output tmcr_sts_t                    sts_o,
  output logic signed [POS_W-1:0]      new_x_o,
  output logic signed [POS_W-1:0]      new_y_o,
  output logic                         collided_o
);

  localparam int unsigned TW      = TILE_SIZE_PX << FRACTION_BITS;
  localparam int unsigned HALF    = TW >> 1;
  localparam int unsigned CX_W    = POS_W + 1;
  localparam int unsigned V_W     = POS_W;
  localparam int unsigned R_W     = 26;
  localparam int unsigned DIV_SH  = V_W + $clog2(TILE_SIZE_PX);
  localparam int unsigned TX_W    = V_W + 1 - $clog2(TILE_SIZE_PX);
  localparam longint unsigned R_L =
    ((64'd1 << DIV_SH) + 64'(TILE_SIZE_PX) - 64'd1) / 64'(TILE_SIZE_PX);
  localparam logic [R_W-1:0] R_C  = R_W'(R_L);
  localparam int unsigned DIM_MAX = (MAX_MAP_COLS > MAX_MAP_ROWS) ? MAX_MAP_COLS : MAX_MAP_ROWS;
  localparam int unsigned W_RAW   = $clog2(DIM_MAX + 1) + $clog2(TW + 1) + 3;
  localparam int unsigned W       = (W_RAW > 28) ? W_RAW : 28;
  localparam int unsigned DEPTH   = MAX_MAP_COLS * MAX_MAP_ROWS;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [W-1:0] SAT_HI = W'(32'sd8388607);
  localparam logic signed [W-1:0] SAT_LO = W'(-32'sd8388608);

  logic [DIM_W-1:0]  cols_q, rows_q;
  logic [SIZE_W-1:0] size_q, rad_q;

  logic signed [POS_W-1:0] px0_q, py0_q;
  logic signed [W-1:0]     pos_x_q, pos_y_q;
  logic signed [CX_W-1:0]  corn_x_d, corn_y_d, corn_x_q, corn_y_q;
  logic [CX_W-1:0]         sh_x, sh_y;
  logic [V_W+R_W-1:0]      prod_x, prod_y;
  logic [TX_W-1:0]         tx_q, ty_q;
  logic                    neg_q;
  logic                    in_map_d, in_map_q;
  logic [ADDR_W-1:0]       raddr, waddr;
  logic                    wr_ok;
  logic                    mem_q [DEPTH];
  logic                    rd_q;
  logic signed [W-1:0]     cx_q, cy_q;
  logic signed [W-1:0]     dx_q, dy_q;
  logic signed [W-1:0]     xd_q, yd_q;
  logic signed [W-1:0]     min_d, abs_dx, abs_dy;
  logic                    xd_pos, yd_pos;
  logic                    coll_q;
  logic signed [W-1:0]     sat_x, sat_y;
  logic signed [POS_W-1:0] new_x_q, new_y_q;
  logic                    collided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= MAP_COLS_RST;
      rows_q <= MAP_ROWS_RST;
      size_q <= AGENT_SIZE_RST;
      rad_q  <= AGENT_RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MAP_COLS:     cols_q <= cfg_data_i[DIM_W-1:0];
        REG_MAP_ROWS:     rows_q <= cfg_data_i[DIM_W-1:0];
        REG_AGENT_SIZE:   size_q <= cfg_data_i[SIZE_W-1:0];
        REG_AGENT_RADIUS: rad_q  <= cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign corn_x_d = $signed({px0_q[POS_W-1], px0_q})
                  + (cmd_i.corner[0] ? $signed({5'b00000, size_q}) : $signed(CX_W'(0)));
  assign corn_y_d = $signed({py0_q[POS_W-1], py0_q})
                  + (cmd_i.corner[1] ? $signed({5'b00000, size_q}) : $signed(CX_W'(0)));

  assign sh_x   = corn_x_q >> FRACTION_BITS;
  assign sh_y   = corn_y_q >> FRACTION_BITS;
  assign prod_x = (V_W+R_W)'(sh_x[V_W-1:0]) * (V_W+R_W)'(R_C);
  assign prod_y = (V_W+R_W)'(sh_y[V_W-1:0]) * (V_W+R_W)'(R_C);

  assign in_map_d = !neg_q
                  && (32'(tx_q) < 32'(cols_q)) && (32'(tx_q) < 32'(MAX_MAP_COLS))
                  && (32'(ty_q) < 32'(rows_q)) && (32'(ty_q) < 32'(MAX_MAP_ROWS));
  assign raddr = ADDR_W'(32'(ty_q) * 32'(MAX_MAP_COLS) + 32'(tx_q));
  assign waddr = ADDR_W'(32'(cell_row_i) * 32'(MAX_MAP_COLS) + 32'(cell_col_i));
  assign wr_ok = (32'(cell_col_i) < 32'(MAX_MAP_COLS)) && (32'(cell_row_i) < 32'(MAX_MAP_ROWS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_wr && wr_ok) begin
      mem_q[waddr] <= cell_solid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q     <= mem_q[raddr];
      in_map_q <= in_map_d;
    end
  end

  assign sts_o.hit = rd_q && in_map_q;

  assign min_d  = W'(rad_q) + W'(HALF);
  assign abs_dx = dx_q[W-1] ? -dx_q : dx_q;
  assign abs_dy = dy_q[W-1] ? -dy_q : dy_q;
  assign xd_pos = !xd_q[W-1] && (xd_q != '0);
  assign yd_pos = !yd_q[W-1] && (yd_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px0_q   <= pos_x_i;
      py0_q   <= pos_y_i;
      pos_x_q <= W'(pos_x_i);
      pos_y_q <= W'(pos_y_i);
      coll_q  <= 1'b0;
    end
    if (cmd_i.corn_en) begin
      corn_x_q <= corn_x_d;
      corn_y_q <= corn_y_d;
    end
    if (cmd_i.div_en) begin
      tx_q  <= prod_x[DIV_SH +: TX_W];
      ty_q  <= prod_y[DIV_SH +: TX_W];
      neg_q <= corn_x_q[CX_W-1] || corn_y_q[CX_W-1];
    end
    if (cmd_i.cent_en) begin
      cx_q <= $signed(W'(tx_q) * W'(TW) + W'(HALF));
      cy_q <= $signed(W'(ty_q) * W'(TW) + W'(HALF));
      if (sts_o.hit) begin
        coll_q <= 1'b1;
      end
    end
    if (cmd_i.diff_en) begin
      dx_q <= pos_x_q + W'(rad_q) - cx_q;
      dy_q <= pos_y_q + W'(rad_q) - cy_q;
    end
    if (cmd_i.depth_en) begin
      xd_q <= min_d - abs_dx;
      yd_q <= min_d - abs_dy;
    end
    if (cmd_i.push_en && xd_pos && yd_pos) begin
      if (xd_q < yd_q) begin
        pos_x_q <= dx_q[W-1] ? pos_x_q - xd_q : pos_x_q + xd_q;
      end else begin
        pos_y_q <= dy_q[W-1] ? pos_y_q - yd_q : pos_y_q + yd_q;
      end
    end
  end

  assign sat_x = (pos_x_q > SAT_HI) ? SAT_HI : ((pos_x_q < SAT_LO) ? SAT_LO : pos_x_q);
  assign sat_y = (pos_y_q > SAT_HI) ? SAT_HI : ((pos_y_q < SAT_LO) ? SAT_LO : pos_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        SRC_LOAD: begin
          new_x_q    <= pos_x_i;
          new_y_q    <= pos_y_i;
          collided_q <= 1'b0;
        end
        SRC_RESOLVE: begin
          new_x_q    <= sat_x[POS_W-1:0];
          new_y_q    <= sat_y[POS_W-1:0];
          collided_q <= coll_q;
        end
        default: begin
          collided_q <= 1'b0;
        end
      endcase
    end
  end

  assign new_x_o    = new_x_q;
  assign new_y_o    = new_y_q;
  assign collided_o = collided_q;

endmodule

`default_nettype wire
